### rtl/bt_pkg.sv
// Package for the breakpoint table: entry type, command codes, sequencer state, per-cell control.
// Used by bt_cell and breakpoint_table. No dependencies.
`default_nettype none

package bt_pkg;

	typedef struct packed {
		logic [3:0]  flags;
		logic [3:0]  space;
		logic [31:0] start_addr;
		logic [31:0] end_addr;
	} entry_t;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_ADD    = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic cmp;
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

`default_nettype wire

### rtl/bt_cell.sv
// One slot of the breakpoint table: holds an entry, compares it with a probe
// and takes either a new entry or its upper neighbor's entry. Uses bt_pkg.
`default_nettype none

module bt_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bt_pkg::cell_ctl_t ctl,
	input  wire bt_pkg::entry_t    probe,
	input  wire bt_pkg::entry_t    fill,
	input  wire bt_pkg::entry_t    next_entry,
	output bt_pkg::entry_t         entry,
	output logic                   match
);

	bt_pkg::entry_t entry_q;
	logic           match_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= fill;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp) begin
			match_q <= (entry_q == probe);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

`default_nettype wire

### rtl/breakpoint_table.sv
// Breakpoint table top level: a row of bt_cell slots, command sequencer,
// result register. Uses bt_pkg and bt_cell.
//
// Usage: a request on the input channel (in_valid, in_stall) carries one
// command: read the entry at index, remove the entry at index (later entries
// move down one slot), or add an entry (returns the slot of an equal entry,
// or appends it). Each request gives exactly one result on the output channel
// (out_valid, out_stall) with status, slot and the entry fields of a read.
// out_valid rises at the edge that ends the execute state. At the accepting
// edge every cell compares its entry with the request; at the edge that ends
// the execute state the match flags are encoded, the cells shift or load in
// parallel and the result is registered. A new request is accepted only after
// the previous one has left the execute state. A request may be accepted while
// the previous result still waits; if the receiver stalls, that result holds
// and the next command waits in its execute state until the register frees.
// Reset empties the table (count of zero) and drops any pending result.
`default_nettype none

module breakpoint_table #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [3:0]  index,
	input  wire logic [3:0]  in_flags,
	input  wire logic [3:0]  in_space,
	input  wire logic [31:0] in_start,
	input  wire logic [31:0] in_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [3:0]       slot,
	output logic [3:0]       out_flags,
	output logic [3:0]       out_space,
	output logic [31:0]      out_start,
	output logic [31:0]      out_end
);

	localparam int POS_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (POS_W > 4) ? POS_W : 4;

	bt_pkg::state_t    state_q, state_d;
	bt_pkg::cmd_t      cmd_q;
	logic [3:0]        index_q;
	bt_pkg::entry_t    key_q;
	bt_pkg::entry_t    probe;
	logic [POS_W-1:0]  count_q;

	bt_pkg::cell_ctl_t ctl   [MAX_ENTRIES];
	bt_pkg::entry_t    cells [MAX_ENTRIES];
	bt_pkg::entry_t    nexts [MAX_ENTRIES];
	logic              match [MAX_ENTRIES];

	logic              accept;
	logic              exec_go;
	logic              idx_bad;
	logic              found;
	logic [POS_W-1:0]  found_pos;
	logic              full;
	logic              do_remove;
	logic              do_append;
	bt_pkg::entry_t    read_entry;

	logic              res_status;
	logic [3:0]        res_slot;
	bt_pkg::entry_t    res_entry;
	logic [POS_W+3:0]  slot_ext;

	logic              out_valid_q;
	logic              status_q;
	logic [3:0]        slot_q;
	bt_pkg::entry_t    out_entry_q;

	assign accept  = in_valid && !in_stall;
	assign probe   = '{flags: in_flags, space: in_space, start_addr: in_start, end_addr: in_end};
	assign idx_bad = CMP_W'(index_q) >= CMP_W'(count_q);
	assign full    = count_q == POS_W'(MAX_ENTRIES);

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		exec_go  = 1'b0;
		case (state_q)
			bt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = bt_pkg::ST_EXEC;
				end
			end
			bt_pkg::ST_EXEC: begin
				if (!out_valid_q || !out_stall) begin
					exec_go = 1'b1;
					state_d = bt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= bt_pkg::cmd_t'(cmd);
			index_q <= index;
			key_q   <= probe;
		end
	end

	always_comb begin
		found     = 1'b0;
		found_pos = '0;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match[i] && (POS_W'(i) < count_q)) begin
				found     = 1'b1;
				found_pos = POS_W'(i);
			end
		end
	end

	always_comb begin
		read_entry = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (CMP_W'(index_q) == CMP_W'(i)) begin
				read_entry = cells[i];
			end
		end
	end

	assign do_remove = exec_go && (cmd_q == bt_pkg::CMD_REMOVE) && !idx_bad;
	assign do_append = exec_go && (cmd_q == bt_pkg::CMD_ADD) && !found && !full;

	always_comb begin
		res_status = 1'b0;
		res_entry  = '0;
		slot_ext   = '0;
		case (cmd_q)
			bt_pkg::CMD_READ: begin
				if (idx_bad) begin
					res_status = 1'b1;
				end else begin
					res_entry = read_entry;
				end
			end
			bt_pkg::CMD_REMOVE: begin
				res_status = idx_bad;
			end
			bt_pkg::CMD_ADD: begin
				if (found) begin
					slot_ext = {4'd0, found_pos};
				end else if (full) begin
					res_status = 1'b1;
				end else begin
					slot_ext = {4'd0, count_q};
				end
			end
			default: begin
				res_status = 1'b1;
			end
		endcase
		res_slot = slot_ext[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_remove) begin
			count_q <= count_q - POS_W'(1);
		end else if (do_append) begin
			count_q <= count_q + POS_W'(1);
		end
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		if (g == MAX_ENTRIES - 1) begin : g_last
			assign nexts[g] = key_q;
		end else begin : g_mid
			assign nexts[g] = cells[g + 1];
		end

		assign ctl[g].cmp   = accept;
		assign ctl[g].shift = do_remove && (CMP_W'(g) >= CMP_W'(index_q));
		assign ctl[g].load  = do_append && (POS_W'(g) == count_q);

		bt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[g]),
			.probe      (probe),
			.fill       (key_q),
			.next_entry (nexts[g]),
			.entry      (cells[g]),
			.match      (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q    <= res_status;
			slot_q      <= res_slot;
			out_entry_q <= res_entry;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign out_flags = out_entry_q.flags;
	assign out_space = out_entry_q.space;
	assign out_start = out_entry_q.start_addr;
	assign out_end   = out_entry_q.end_addr;

endmodule

`default_nettype wire
